// ----- rtl/binary_max_heap_priority_queue_macros.svh -----
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_macros.svh
// Assertion macros shared by the heap priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define BMH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BMH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bmh_pkg.sv -----
// ----------------------------------------------------------------------------
// bmh_pkg
// Types and constants of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmh_pkg;

	localparam int DATA_W = 32;
	localparam int STAT_W = 2;

	// operation codes
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_EX_LAST,
		S_EX_CUR,
		S_DN_RD_L,
		S_DN_RD_R,
		S_DN_CMP_R,
		S_DN_DEC,
		S_UP_RD,
		S_UP_CMP,
		S_DONE
	} bmh_state_t;

	// one operation handed to the sequencer
	typedef struct packed {
		logic                     opcode;
		logic signed [DATA_W-1:0] value;
	} bmh_req_t;

	// one finished result from the sequencer
	typedef struct packed {
		logic signed [DATA_W-1:0] max_value;
		logic [STAT_W-1:0]        status;
	} bmh_res_t;

endpackage

// ----- rtl/bmh_in_if.sv -----
// ----------------------------------------------------------------------------
// bmh_in_if
// Operation channel: opcode and value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmh_in_if;
	logic                              valid;
	logic                              ready;
	logic                              opcode;
	logic signed [bmh_pkg::DATA_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

// ----- rtl/bmh_out_if.sv -----
// ----------------------------------------------------------------------------
// bmh_out_if
// Result channel: extracted maximum and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmh_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [bmh_pkg::DATA_W-1:0] max_value;
	logic [bmh_pkg::STAT_W-1:0]        status;

	modport source (output valid, output max_value, output status, input ready);
	modport sink (input valid, input max_value, input status, output ready);
endinterface

// ----- rtl/bmh_ram.sv -----
// ----------------------------------------------------------------------------
// bmh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/bmh_seq.sv -----
// ----------------------------------------------------------------------------
// bmh_seq
// Heap sequencer: owns the heap RAM and entry count, runs sift-up and
// sift-down one level at a time through a single shared signed comparator.
// ----------------------------------------------------------------------------
module bmh_seq #(
	parameter int HEAP_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  bmh_pkg::bmh_req_t                 req,
	output logic                              idle,
	output logic                              done_valid,
	input  logic                              done_take,
	output bmh_pkg::bmh_res_t                 done,
	output logic [$clog2(HEAP_DEPTH+1)-1:0]   count
);

	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int LW = AW + 2;
	localparam int DW = bmh_pkg::DATA_W;

	bmh_pkg::bmh_state_t state_q, state_d;

	logic [CW-1:0]          count_q, count_d;
	logic [AW-1:0]          pos_q, pos_d;
	logic [AW-1:0]          best_idx_q, best_idx_d;
	logic signed [DW-1:0]   cur_q, cur_d;
	logic signed [DW-1:0]   best_val_q, best_val_d;
	logic signed [DW-1:0]   top_q, top_d;
	logic [bmh_pkg::STAT_W-1:0] status_q, status_d;

	// RAM port signals
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [DW-1:0]        ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [DW-1:0]        ram_rdata;
	logic signed [DW-1:0] rd_data;

	// shared comparator
	logic signed [DW-1:0] cmp_a, cmp_b;
	logic                 cmp_gt;

	// index arithmetic
	logic [LW-1:0] lc_idx, rc_idx, count_ext;
	logic [AW-1:0] pos_dec, parent_idx;
	logic [CW-1:0] count_dec;

	bmh_ram #(
		.WIDTH(DW),
		.DEPTH(HEAP_DEPTH)
	) u_heap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_data    = signed'(ram_rdata);
	assign lc_idx     = {1'b0, pos_q, 1'b1};
	assign rc_idx     = lc_idx + LW'(1);
	assign count_ext  = LW'(count_q);
	assign pos_dec    = pos_q - AW'(1);
	assign parent_idx = pos_dec >> 1;
	assign count_dec  = count_q - CW'(1);

	// steer operands into the one comparator
	always_comb begin
		case (state_q)
			bmh_pkg::S_UP_CMP: begin
				cmp_a = cur_q;
				cmp_b = rd_data;
			end
			bmh_pkg::S_DN_CMP_R: begin
				cmp_a = rd_data;
				cmp_b = best_val_q;
			end
			default: begin
				cmp_a = rd_data;
				cmp_b = cur_q;
			end
		endcase
	end

	assign cmp_gt = cmp_a > cmp_b;

	// next state, datapath updates and RAM control
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		pos_d      = pos_q;
		best_idx_d = best_idx_q;
		cur_d      = cur_q;
		best_val_d = best_val_q;
		top_d      = top_q;
		status_d   = status_q;
		ram_we     = 1'b0;
		ram_waddr  = pos_q;
		ram_wdata  = cur_q;
		ram_re     = 1'b0;
		ram_raddr  = '0;

		case (state_q)
			bmh_pkg::S_IDLE: begin
				if (start) begin
					top_d    = '0;
					status_d = bmh_pkg::STAT_OK;
					if (req.opcode == bmh_pkg::OP_INSERT) begin
						if (count_q == CW'(HEAP_DEPTH)) begin
							status_d = bmh_pkg::STAT_FULL;
							state_d  = bmh_pkg::S_DONE;
						end else begin
							pos_d   = count_q[AW-1:0];
							cur_d   = req.value;
							count_d = count_q + CW'(1);
							state_d = bmh_pkg::S_UP_RD;
						end
					end else begin
						if (count_q == '0) begin
							status_d = bmh_pkg::STAT_EMPTY;
							state_d  = bmh_pkg::S_DONE;
						end else begin
							// fetch the root
							ram_re    = 1'b1;
							ram_raddr = '0;
							state_d   = bmh_pkg::S_EX_LAST;
						end
					end
				end
			end
			bmh_pkg::S_EX_LAST: begin
				// capture root, fetch last entry and shrink
				top_d     = rd_data;
				ram_re    = 1'b1;
				ram_raddr = count_dec[AW-1:0];
				count_d   = count_dec;
				state_d   = bmh_pkg::S_EX_CUR;
			end
			bmh_pkg::S_EX_CUR: begin
				cur_d   = rd_data;
				pos_d   = '0;
				state_d = bmh_pkg::S_DN_RD_L;
			end
			bmh_pkg::S_DN_RD_L: begin
				if (lc_idx < count_ext) begin
					ram_re    = 1'b1;
					ram_raddr = lc_idx[AW-1:0];
					state_d   = bmh_pkg::S_DN_RD_R;
				end else begin
					// leaf: settle the moving entry here
					ram_we  = 1'b1;
					state_d = bmh_pkg::S_DONE;
				end
			end
			bmh_pkg::S_DN_RD_R: begin
				// left child against the moving entry
				if (cmp_gt) begin
					best_idx_d = lc_idx[AW-1:0];
					best_val_d = rd_data;
				end else begin
					best_idx_d = pos_q;
					best_val_d = cur_q;
				end
				if (rc_idx < count_ext) begin
					ram_re    = 1'b1;
					ram_raddr = rc_idx[AW-1:0];
					state_d   = bmh_pkg::S_DN_CMP_R;
				end else begin
					state_d = bmh_pkg::S_DN_DEC;
				end
			end
			bmh_pkg::S_DN_CMP_R: begin
				// right child against the best so far
				if (cmp_gt) begin
					best_idx_d = rc_idx[AW-1:0];
					best_val_d = rd_data;
				end
				state_d = bmh_pkg::S_DN_DEC;
			end
			bmh_pkg::S_DN_DEC: begin
				// write the winner at the node, descend if a child won
				ram_we    = 1'b1;
				ram_wdata = best_val_q;
				if (best_idx_q == pos_q) begin
					state_d = bmh_pkg::S_DONE;
				end else begin
					pos_d   = best_idx_q;
					state_d = bmh_pkg::S_DN_RD_L;
				end
			end
			bmh_pkg::S_UP_RD: begin
				if (pos_q == '0) begin
					ram_we  = 1'b1;
					state_d = bmh_pkg::S_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = parent_idx;
					state_d   = bmh_pkg::S_UP_CMP;
				end
			end
			bmh_pkg::S_UP_CMP: begin
				if (cmp_gt) begin
					// pull the parent down, climb
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					pos_d     = parent_idx;
					state_d   = bmh_pkg::S_UP_RD;
				end else begin
					ram_we  = 1'b1;
					state_d = bmh_pkg::S_DONE;
				end
			end
			bmh_pkg::S_DONE: begin
				if (done_take) begin
					state_d = bmh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bmh_pkg::S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmh_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		best_idx_q <= best_idx_d;
		cur_q      <= cur_d;
		best_val_q <= best_val_d;
		top_q      <= top_d;
		status_q   <= status_d;
	end

	assign idle           = (state_q == bmh_pkg::S_IDLE);
	assign done_valid     = (state_q == bmh_pkg::S_DONE);
	assign done.max_value = top_q;
	assign done.status    = status_q;
	assign count          = count_q;

endmodule

// ----- rtl/binary_max_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Max-heap priority queue of signed 32-bit values: insert or extract maximum,
// one result word per operation word.
// ----------------------------------------------------------------------------
// Operations are handled one at a time. An insert starts at the end of the
// heap and climbs level by level, reading the parent and comparing, until
// the parent is not smaller or it reaches the root. An extract reads the
// root, moves the last entry to the top and sinks it level by level, reading
// and comparing each child, until it reaches a leaf or no child is larger.
// Both climb and descent cover at most log2(HEAP_DEPTH) levels. A full
// insert or an empty extract goes straight to its result. Operation time is
// set by the single read port of the heap RAM and the one shared comparator:
// each level needs a registered read and a compare per entry examined. The
// result register lets a new operation word in while the previous result
// word still waits on the output channel. No clearing pass is needed after
// reset.
module binary_max_heap_priority_queue #(
	parameter int HEAP_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	bmh_in_if.sink       cmd,
	bmh_out_if.source    rsp
);

	localparam int CW = $clog2(HEAP_DEPTH + 1);

	bmh_pkg::bmh_req_t req;
	bmh_pkg::bmh_res_t done;
	bmh_pkg::bmh_res_t res_q;
	logic              seq_idle;
	logic              seq_done;
	logic              done_take;
	logic              rsp_valid_q;
	logic [CW-1:0]     count;
	logic              cmd_fire;
	logic              res_full;
	logic              res_empty;

	assign req.opcode = cmd.opcode;
	assign req.value  = cmd.value;
	assign cmd.ready  = seq_idle;
	assign cmd_fire   = cmd.valid && cmd.ready;

	bmh_seq #(
		.HEAP_DEPTH(HEAP_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cmd_fire),
		.req        (req),
		.idle       (seq_idle),
		.done_valid (seq_done),
		.done_take  (done_take),
		.done       (done),
		.count      (count)
	);

	// move a finished result into the output register when it is free
	assign done_take = seq_done && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_take) begin
			res_q <= done;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.max_value = res_q.max_value;
	assign rsp.status    = res_q.status;

	// status of the result being handed over
	assign res_full  = done_take && (done.status == bmh_pkg::STAT_FULL);
	assign res_empty = done_take && (done.status == bmh_pkg::STAT_EMPTY);

`include "binary_max_heap_priority_queue_macros.svh"

	`BMH_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(HEAP_DEPTH), "entry count over depth")
	`BMH_ASSERT_NOW(a_full_status, res_full, count == CW'(HEAP_DEPTH), "full status with room left")
	`BMH_ASSERT_NOW(a_empty_status, res_empty, count == '0, "empty status with entries held")
	`BMH_ASSERT_NEXT(a_busy_after_accept, cmd_fire, !cmd.ready, "ready right after accepting a word")

endmodule
